[design/aeske_pkg.sv]
// Shared types, constants and the S-box for the AES-128 key expansion core.
package aeske_pkg;

	localparam int unsigned ROUND_W = 4;
	localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd10;
	localparam logic [7:0] RCON_INIT = 8'h01;
	localparam logic [7:0] RCON_POLY = 8'h1B;

	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
	} key_t;

	typedef struct packed {
		logic [ROUND_W-1:0] round_index;
		logic [63:0]        round_key_high;
		logic [63:0]        round_key_low;
		logic               last_round;
	} result_t;

	typedef struct packed {
		logic load;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
		8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
		8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
		8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
		8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
		8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
		8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
		8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
		8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
		8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
		8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
		8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
		8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
		8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
		8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
		8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
		8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

[design/aeske_ctrl.sv]
// Controller state machine that sequences the eleven round key results of one key.
module aeske_ctrl
	import aeske_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic result_valid
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		busy         = 1'b0;
		result_valid = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				if (start) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				result_valid = 1'b1;
				busy         = !sts.last;
				cmd.advance  = !sts.last;
				cmd.load     = sts.last && start;
				if (sts.last && !start) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[design/aeske_datapath.sv]
// Datapath that holds the working round key and computes the next one each cycle.
module aeske_datapath
	import aeske_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  key_t    key,
	output sts_t    sts,
	output result_t result
);

	logic [31:0]        w0_q, w1_q, w2_q, w3_q;
	logic [7:0]         rcon_q;
	logic [ROUND_W-1:0] round_q;
	logic [31:0]        temp;
	logic [31:0]        n0, n1, n2, n3;

	always_comb begin
		temp = sub_word({w3_q[23:0], w3_q[31:24]}) ^ {rcon_q, 24'h000000};
		n0   = w0_q ^ temp;
		n1   = w1_q ^ n0;
		n2   = w2_q ^ n1;
		n3   = w3_q ^ n2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.load) begin
			round_q <= '0;
		end else if (cmd.advance) begin
			round_q <= round_q + ROUND_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q   <= '0;
			w1_q   <= '0;
			w2_q   <= '0;
			w3_q   <= '0;
			rcon_q <= '0;
		end else if (cmd.load) begin
			w0_q   <= key.key_high[63:32];
			w1_q   <= key.key_high[31:0];
			w2_q   <= key.key_low[63:32];
			w3_q   <= key.key_low[31:0];
			rcon_q <= RCON_INIT;
		end else if (cmd.advance) begin
			w0_q   <= n0;
			w1_q   <= n1;
			w2_q   <= n2;
			w3_q   <= n3;
			rcon_q <= {rcon_q[6:0], 1'b0} ^ (rcon_q[7] ? RCON_POLY : 8'h00);
		end
	end

	assign sts.last              = (round_q == LAST_ROUND);
	assign result.round_index    = round_q;
	assign result.round_key_high = {w0_q, w1_q};
	assign result.round_key_low  = {w2_q, w3_q};
	assign result.last_round     = sts.last;

endmodule

[design/aes128_key_expansion_core.sv]
// Top level of the AES-128 key expansion core.
//
// Channel   Direction  Handshake                    Payload
// key       in         start high while busy low    key_t (key_high, key_low)
// result    out        result_valid, one cycle each result_t (round, key, last)
//
// A key accepted at one edge shows round key 0 in the next cycle and one further
// round key in each following cycle, so a transaction yields eleven results; a
// single round unit derives each key from the one before it. A new key may be
// started in the cycle that shows round 10. Reset returns the controller to idle
// with no result pending. The receiver cannot stall, so no result is ever held
// back.
module aes128_key_expansion_core
	import aeske_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  key_t    key,
	output logic    busy,
	output logic    result_valid,
	output result_t result
);

	cmd_t cmd;
	sts_t sts;

	aeske_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	aeske_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.key    (key),
		.sts    (sts),
		.result (result)
	);

endmodule

[design/aeske_checker.sv]
// Port-level assertions for the AES-128 key expansion core and their bind.
module aeske_checker
	import aeske_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_valid,
	input result_t result
);

	a_accept_gives_round0: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> result_valid && (result.round_index == '0))
		else $error("Accepted transaction did not show round key 0 next.");

	a_rounds_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_round |=> result_valid &&
		(result.round_index == $past(result.round_index) + 4'd1))
		else $error("Round keys did not follow in order.");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last_round == (result.round_index == LAST_ROUND)))
		else $error("Last round flag does not match round index.");

	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !busy)
		else $error("Busy raised with no transaction in progress.");

endmodule

bind aes128_key_expansion_core aeske_checker u_aeske_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

[tb/sv/aes128_key_expansion_core_tb.sv]
// Self-checking testbench for the AES-128 key expansion core, with its own round key predictor.
module aes128_key_expansion_core_tb;
	import aeske_pkg::*;

	localparam int N_RANDOM = 260;
	localparam int N_CALM_TAIL = 40;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 20;
	localparam int RESET_CYCLES = 8;
	localparam logic [7:0] AFFINE_C = 8'h63;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	key_t    key = '0;
	logic    busy;
	logic    result_valid;
	result_t result;

	key_t    key_q[$];
	bit      drain_q[$];
	result_t round_key_q[$];
	int      n_items = 0;
	int      n_sent = 0;
	int      gap = 0;
	bit      drained = 1'b1;
	int      fail_cnt = 0;

	aes128_key_expansion_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.key         (key),
		.busy        (busy),
		.result_valid(result_valid),
		.result      (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? RCON_POLY : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		int i;
		p = '0;
		for (i = 0; i < 8; i++) begin
			if (b[i]) begin
				p ^= a;
			end
			a = xtime(a);
		end
		return p;
	endfunction

	// The S-box is the field inverse (x^254) followed by the affine transform.
	function automatic logic [7:0] sbox_of(input logic [7:0] x);
		logic [7:0] sq;
		logic [7:0] inv;
		int i;
		sq = x;
		inv = 8'h01;
		for (i = 1; i < 8; i++) begin
			sq = gf_mul(sq, sq);
			inv = gf_mul(inv, sq);
		end
		return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
			{inv[3:0], inv[7:4]} ^ AFFINE_C;
	endfunction

	function automatic logic [31:0] sub_bytes_word(input logic [31:0] w);
		return {sbox_of(w[31:24]), sbox_of(w[23:16]), sbox_of(w[15:8]), sbox_of(w[7:0])};
	endfunction

	task automatic expand_key(input key_t k);
		logic [31:0] w [4];
		logic [31:0] t;
		logic [7:0]  rc;
		result_t     rk;
		int          r;
		w[0] = k.key_high[63:32];
		w[1] = k.key_high[31:0];
		w[2] = k.key_low[63:32];
		w[3] = k.key_low[31:0];
		rc = RCON_INIT;
		for (r = 0; r <= LAST_ROUND; r++) begin
			if (r != 0) begin
				t = sub_bytes_word({w[3][23:0], w[3][31:24]}) ^ {rc, 24'h000000};
				w[0] ^= t;
				w[1] ^= w[0];
				w[2] ^= w[1];
				w[3] ^= w[2];
				rc = xtime(rc);
			end
			rk.round_index = r[ROUND_W-1:0];
			rk.round_key_high = {w[0], w[1]};
			rk.round_key_low = {w[2], w[3]};
			rk.last_round = (r == LAST_ROUND);
			round_key_q.push_back(rk);
		end
	endtask

	task automatic add_key(input logic [63:0] hi, input logic [63:0] lo, input bit drain);
		key_t k;
		k.key_high = hi;
		k.key_low = lo;
		key_q.push_back(k);
		drain_q.push_back(drain);
	endtask

	always @(negedge clk) begin
		drained = (round_key_q.size() == 0);
	end

	always @(posedge clk) begin
		logic next_start;
		key_t next_key;
		if (start && !busy) begin
			expand_key(key);
			void'(key_q.pop_front());
			void'(drain_q.pop_front());
			n_sent++;
		end
		next_start = 1'b0;
		next_key = key;
		if (gap > 0) begin
			gap--;
		end else if (arst_n && key_q.size() != 0) begin
			if (n_sent < n_items - N_CALM_TAIL && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(0, 4);
			end else if (!drain_q[0] || drained) begin
				next_start = 1'b1;
				next_key = key_q[0];
			end
		end
		start <= next_start;
		key <= next_key;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (round_key_q.size() == 0) begin
				$error("unexpected transaction: round_index %0d", result.round_index);
				fail_cnt++;
			end else begin
				want = round_key_q.pop_front();
				if (result.round_index !== want.round_index) begin
					$error("round_index: expected %0d, actual %0d",
						want.round_index, result.round_index);
					fail_cnt++;
				end
				if (result.round_key_high !== want.round_key_high) begin
					$error("round_key_high: expected %h, actual %h",
						want.round_key_high, result.round_key_high);
					fail_cnt++;
				end
				if (result.round_key_low !== want.round_key_low) begin
					$error("round_key_low: expected %h, actual %h",
						want.round_key_low, result.round_key_low);
					fail_cnt++;
				end
				if (result.last_round !== want.last_round) begin
					$error("last_round: expected %0b, actual %0b",
						want.last_round, result.last_round);
					fail_cnt++;
				end
			end
		end
	end

	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_valid) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("[aes128_key_expansion_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		int i;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [7:0] b;
		add_key(64'h0, 64'h0, 1'b1);
		add_key('1, '1, 1'b0);
		add_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b0);
		add_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b0);
		add_key({16{4'ha}}, {16{4'h5}}, 1'b0);
		add_key({16{4'h5}}, {16{4'ha}}, 1'b0);
		add_key(64'h8000000000000000, 64'h0, 1'b0);
		add_key(64'h0, 64'h1, 1'b0);
		add_key(64'h1, 64'h8000000000000000, 1'b0);
		add_key(64'h0, 64'h00000000ffffffff, 1'b0);
		add_key(64'hffffffff00000000, 64'h0, 1'b0);
		add_key(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
		add_key(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
		for (i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(0, 3))
				0: begin
					hi = {$urandom, $urandom};
					lo = {$urandom, $urandom};
				end
				1: begin
					hi = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
					lo = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
				end
				2: begin
					hi = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
					lo = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
				end
				default: begin
					b = 8'($urandom);
					hi = {8{b}};
					b = 8'($urandom);
					lo = {8{b}};
				end
			endcase
			add_key(hi, lo, (i % 60) == 30);
		end
		n_items = key_q.size();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		while (key_q.size() != 0 || round_key_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("[aes128_key_expansion_core] OK");
		end else begin
			$display("[aes128_key_expansion_core] ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
design/aeske_pkg.sv
design/aeske_ctrl.sv
design/aeske_datapath.sv
design/aes128_key_expansion_core.sv
design/aeske_checker.sv
tb/sv/aes128_key_expansion_core_tb.sv
